FILE: hdl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types for the periodic timer queue: transfer payloads, opcodes,
// controller states and the slot count.
// ----------------------------------------------------------------------------
package ptq_pkg;

  // Slot count; the payload index and count fields are sized for it
  localparam int NUM_TIMERS = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } ptq_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } ptq_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  timer_index;
    logic [23:0] timeout;
    logic        periodic_mode;
  } ptq_in_t;

  typedef struct packed {
    logic       expiry_valid;
    logic [3:0] expired_index;
    logic       last_of_run;
    logic [4:0] active_count;
  } ptq_out_t;

endpackage

FILE: hdl/ptq_ram.sv
// ----------------------------------------------------------------------------
// ptq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/periodic_timer_queue_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_queue_top
// Bank of one-shot / periodic timer slots sharing one time counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command
//   per transfer: tick (advance time by one), start slot, or stop slot.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns results.
//   Start and stop give one result; a tick gives one result per expired slot
//   in ascending slot order (last one marked), or a single empty result.
//   Every result carries the count of armed slots after the command.
// Timing:
//   Start / stop: result registered on the next edge.
//   Tick: after acceptance the slot RAM is scanned (one slot per cycle
//   through its single read port), then slot indices are walked, one per
//   cycle (pausing on an expired slot while output stalls) to the last expiry.
//   A new command is taken only after the previous one finished its scan
//   and emission, and while the output register is free or being drained.
// Reset: time counter, armed flags and count clear; slot RAM needs no clear
//   since its entries are only used once armed.
// Stall: the output register holds its result while out_stall_i is high;
//   emission pauses and the input stalls until it drains.
// ----------------------------------------------------------------------------
module periodic_timer_queue_top
  import ptq_pkg::*;
#(
  parameter int TIME_WIDTH    = 32,
  parameter int TIMEOUT_WIDTH = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ptq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ptq_out_t out_data_o
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int RAM_W = 1 + TIMEOUT_WIDTH + TIME_WIDTH;
  localparam int SUM_W = (TIME_WIDTH > TIMEOUT_WIDTH) ? TIME_WIDTH : TIMEOUT_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  // Controller state
  ptq_state_e state_q, state_d;

  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [NUM_TIMERS-1:0] armed_q, armed_d;   // per-slot valid bits
  logic [NUM_TIMERS-1:0] exp_q, exp_d;       // slots expired on this tick
  logic [CNT_W-1:0]      cnt_q, cnt_d;       // armed slot count
  logic [CNT_W-1:0]      exp_cnt_q, exp_cnt_d; // expiries left to send

  // Scan pipeline: read issue index and slot whose data is back
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_act_q, rd_act_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;            // emission walk pointer

  // Output register
  logic     out_valid_q, out_valid_d;
  ptq_out_t out_q, out_d;
  logic     out_load;
  logic     out_free;

  // Slot RAM: {repeats, period, deadline}
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  logic                     rd_rep;
  logic [TIMEOUT_WIDTH-1:0] rd_period;
  logic [TIME_WIDTH-1:0]    rd_deadline;
  logic [TIME_WIDTH-1:0]    diff;

  logic                     in_acc;
  logic                     in_range;
  logic [IDX_W-1:0]         in_slot;
  logic [TIMEOUT_WIDTH-1:0] in_tmo;
  logic [TIMEOUT_WIDTH-1:0] add_op;
  logic [TIME_WIDTH-1:0]    new_deadline;

  logic scan_end;
  logic emit_last;

  ptq_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_TIMERS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_rep      = ram_rdata[RAM_W-1];
  assign rd_period   = ram_rdata[TIME_WIDTH +: TIMEOUT_WIDTH];
  assign rd_deadline = ram_rdata[TIME_WIDTH-1:0];

  // Wrap-aware due check: due when (now - deadline) has its top bit clear
  assign diff = time_q - rd_deadline;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_range = int'(in_data_i.timer_index) < NUM_TIMERS;
  assign in_slot  = IDX_W'(in_data_i.timer_index);
  assign in_tmo   = TIMEOUT_WIDTH'(in_data_i.timeout);

  // One adder for both start deadlines and periodic reloads
  assign add_op       = (state_q == ST_IDLE) ? in_tmo : rd_period;
  assign new_deadline = TIME_WIDTH'(SUM_W'(time_q) + SUM_W'(add_op));

  assign scan_end  = chk_vld_q && (chk_idx_q == LAST_IDX);
  assign emit_last = exp_q[ptr_q] && out_free && (exp_cnt_q == CNT_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.opcode == OP_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = (exp_cnt_d == '0) ? ST_EMPTY : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM access
  always_comb begin
    time_d    = time_q;
    armed_d   = armed_q;
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    exp_cnt_d = exp_cnt_q;
    rd_idx_d  = rd_idx_q;
    rd_act_d  = rd_act_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = 1'b0;
    ptr_d     = ptr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = in_slot;
    ram_raddr = rd_idx_q;
    ram_wdata = {in_data_i.periodic_mode, in_tmo, new_deadline};
    out_load  = 1'b0;
    out_d     = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.opcode)
            OP_TICK: begin
              // Advance time, then scan from slot zero
              time_d    = time_q + TIME_WIDTH'(1);
              exp_d     = '0;
              exp_cnt_d = '0;
              rd_idx_d  = '0;
              rd_act_d  = 1'b1;
            end
            OP_START: begin
              if (in_range) begin
                ram_we           = 1'b1;
                armed_d[in_slot] = 1'b1;
                if (!armed_q[in_slot]) begin
                  cnt_d = cnt_q + CNT_W'(1);
                end
              end
              out_load = 1'b1;
            end
            default: begin
              // Stop, and unused codes answered the same way
              if (in_range && armed_q[in_slot]) begin
                armed_d[in_slot] = 1'b0;
                cnt_d            = cnt_q - CNT_W'(1);
              end
              out_load = 1'b1;
            end
          endcase
          out_d = '{expiry_valid: 1'b0, expired_index: '0, last_of_run: 1'b1,
                    active_count: 5'(cnt_d)};
        end
      end

      ST_SCAN: begin
        // Issue the read for the next slot
        if (rd_act_q) begin
          ram_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q;
          if (rd_idx_q == LAST_IDX) begin
            rd_act_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
          end
        end
        // Check the slot whose entry came back; reload or disarm if due
        if (chk_vld_q && armed_q[chk_idx_q] && !diff[TIME_WIDTH-1]) begin
          exp_d[chk_idx_q] = 1'b1;
          exp_cnt_d        = exp_cnt_q + CNT_W'(1);
          if (rd_rep) begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx_q;
            ram_wdata = {rd_rep, rd_period, new_deadline};
          end else begin
            armed_d[chk_idx_q] = 1'b0;
            cnt_d              = cnt_q - CNT_W'(1);
          end
        end
        if (scan_end) begin
          ptr_d = '0;
        end
      end

      ST_EMIT: begin
        if (!exp_q[ptr_q]) begin
          ptr_d = ptr_q + IDX_W'(1);
        end else if (out_free) begin
          out_load  = 1'b1;
          out_d     = '{expiry_valid: 1'b1, expired_index: 4'(ptr_q),
                        last_of_run: (exp_cnt_q == CNT_W'(1)),
                        active_count: 5'(cnt_q)};
          exp_cnt_d = exp_cnt_q - CNT_W'(1);
          ptr_d     = ptr_q + IDX_W'(1);
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{expiry_valid: 1'b0, expired_index: '0, last_of_run: 1'b1,
                       active_count: 5'(cnt_q)};
        end
      end

      default: begin
        out_load = 1'b0;
      end
    endcase

    out_valid_d = out_load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_q      <= '0;
      armed_q     <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      exp_cnt_q   <= '0;
      rd_idx_q    <= '0;
      rd_act_q    <= 1'b0;
      chk_idx_q   <= '0;
      chk_vld_q   <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      armed_q     <= armed_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      exp_cnt_q   <= exp_cnt_d;
      rd_idx_q    <= rd_idx_d;
      rd_act_q    <= rd_act_d;
      chk_idx_q   <= chk_idx_d;
      chk_vld_q   <= chk_vld_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload; no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Armed count tracks the armed flags
  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) == $countones(armed_q))
    else $error("armed count out of step with armed flags");

  // Scan write-back never hits the slot being read
  a_ram_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("slot RAM read and write to the same entry");

  // Emission only runs with expiries still pending
  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (exp_cnt_q != '0))
    else $error("emission with no pending expiry");

  // A marked last result ends the run
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last_of_run) |=> (state_q == ST_IDLE))
    else $error("controller busy after last result");

endmodule
